[rtl/core/sps_pkg.sv]
package sps_pkg;

  // configuration register width and limits
  localparam int CFG_W = 17;
  localparam logic [CFG_W-1:0] SEG_MIN   = 17'd16;
  localparam logic [CFG_W-1:0] SEG_MAX   = 17'd65536;
  localparam logic [CFG_W-1:0] SEG_RESET = 17'd2048;

  localparam int BYTE_W = 8;

  // input beat kinds carried in tuser
  localparam logic ACT_MAP  = 1'b0;
  localparam logic ACT_BYTE = 1'b1;

  // control carried with a packet byte down the pipeline
  typedef struct packed {
    logic valid;
    logic pkt_first;
    logic last;
  } item_ctl_t;

endpackage

[rtl/core/sps_ram.sv]
module sps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/sps_remap.sv]
module sps_remap import sps_pkg::*; #(
  parameter int APID_BITS = 11,
  localparam int DEPTH = 1 << APID_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  // clearing pass
  input  logic                 clr_active,
  input  logic [APID_BITS-1:0] clr_addr,
  // accepted input beat
  input  logic                 acc,
  input  logic                 action,
  input  logic [APID_BITS-1:0] map_orig_apid,
  input  logic [APID_BITS-1:0] map_seg_apid,
  input  logic [BYTE_W-1:0]    data_byte,
  input  logic [APID_BITS-1:0] src_apid,
  input  logic                 src_last,
  // stage 1 toward the segment stage
  input  logic                 s1_adv,
  output item_ctl_t            s1_ctl,
  output logic [BYTE_W-1:0]    s1_byte,
  output logic [APID_BITS-1:0] s1_apid
);

  logic                 in_pkt;
  logic [APID_BITS-1:0] s1_src;
  logic                 byte_acc;
  logic                 map_acc;
  logic                 rm_we;
  logic [APID_BITS-1:0] rm_waddr;
  logic [APID_BITS:0]   rm_wdata;
  logic                 rm_re;
  logic [APID_BITS:0]   rm_q;

  assign byte_acc = acc && (action == ACT_BYTE);
  assign map_acc  = acc && (action == ACT_MAP);

  // remap table word: valid bit over the new apid
  assign rm_we    = clr_active || map_acc;
  assign rm_waddr = clr_active ? clr_addr : map_orig_apid;
  assign rm_wdata = clr_active ? '0 : {1'b1, map_seg_apid};
  assign rm_re    = byte_acc && !in_pkt;

  sps_ram #(
    .WIDTH(APID_BITS + 1),
    .DEPTH(DEPTH)
  ) u_remap_ram (
    .clk  (clk),
    .we   (rm_we),
    .waddr(rm_waddr),
    .wdata(rm_wdata),
    .re   (rm_re),
    .raddr(src_apid),
    .rdata(rm_q)
  );

  // packet tracking at the input side
  always_ff @(posedge clk) begin
    if (rst) begin
      in_pkt <= 1'b0;
    end else if (byte_acc) begin
      in_pkt <= !src_last;
    end
  end

  // stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else if (byte_acc) begin
      s1_ctl.valid     <= 1'b1;
      s1_ctl.pkt_first <= !in_pkt;
      s1_ctl.last      <= src_last;
    end else if (s1_adv) begin
      s1_ctl.valid <= 1'b0;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (byte_acc) begin
      s1_byte <= data_byte;
      s1_src  <= src_apid;
    end
  end

  // unmapped apid passes through
  assign s1_apid = rm_q[APID_BITS] ? rm_q[APID_BITS-1:0] : s1_src;

endmodule

[rtl/core/sps_segment.sv]
module sps_segment import sps_pkg::*; #(
  parameter int APID_BITS = 11,
  parameter int SEQ_BITS  = 14,
  localparam int DEPTH = 1 << APID_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clr_active,
  input  logic [APID_BITS-1:0] clr_addr,
  input  logic [CFG_W-1:0]     max_seg,
  // stage 1 input
  input  item_ctl_t            s1_ctl,
  input  logic [BYTE_W-1:0]    s1_byte,
  input  logic [APID_BITS-1:0] s1_apid,
  output logic                 take,
  // result register
  output logic                 o_valid,
  input  logic                 o_ready,
  output logic [BYTE_W-1:0]    o_byte,
  output logic [APID_BITS-1:0] o_apid,
  output logic [SEQ_BITS-1:0]  o_seq,
  output logic                 o_first_seg,
  output logic                 o_last_seg,
  output logic                 o_seg_start,
  output logic                 o_seg_end
);

  item_ctl_t            s2_ctl;
  logic [BYTE_W-1:0]    s2_byte;
  logic [APID_BITS-1:0] s2_apid;
  logic                 s1_adv;
  logic                 s2_adv;

  logic [CFG_W-1:0]     bytes_in_seg;
  logic                 first_flag;
  logic [APID_BITS-1:0] cur_apid;
  logic [SEQ_BITS-1:0]  cur_seq;
  logic [SEQ_BITS-1:0]  cur_cnt;

  logic                 fwd_valid;
  logic [APID_BITS-1:0] fwd_addr;
  logic [SEQ_BITS-1:0]  fwd_data;

  logic                 sq_we;
  logic                 sq_byte_we;
  logic [APID_BITS-1:0] sq_waddr;
  logic [SEQ_BITS-1:0]  sq_wdata;
  logic                 sq_re;
  logic [SEQ_BITS-1:0]  sq_q;

  logic [CFG_W-1:0]     lim;
  logic [SEQ_BITS-1:0]  base_cnt;
  logic [SEQ_BITS-1:0]  cnt_src;
  logic [SEQ_BITS-1:0]  cnt_inc;
  logic [APID_BITS-1:0] apid_v;
  logic [CFG_W-1:0]     bytes_v;
  logic [CFG_W-1:0]     bytes_inc;
  logic                 first_v;
  logic                 start_v;
  logic                 end_v;
  logic [SEQ_BITS-1:0]  seq_v;

  // stage handshakes
  assign s2_adv = s2_ctl.valid && (!o_valid || o_ready);
  assign take   = !s2_ctl.valid || s2_adv;
  assign s1_adv = s1_ctl.valid && take;

  // stage 2 control and payload
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl <= '0;
    end else if (s1_adv) begin
      s2_ctl <= s1_ctl;
    end else if (s2_adv) begin
      s2_ctl.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_byte <= s1_byte;
      s2_apid <= s1_apid;
    end
  end

  // sequence counter memory, read once per packet
  assign sq_re      = s1_adv && s1_ctl.pkt_first;
  assign sq_byte_we = s2_adv && start_v;
  assign sq_we      = clr_active || sq_byte_we;
  assign sq_waddr   = clr_active ? clr_addr : apid_v;
  assign sq_wdata   = clr_active ? '0 : cnt_inc;

  sps_ram #(
    .WIDTH(SEQ_BITS),
    .DEPTH(DEPTH)
  ) u_seq_ram (
    .clk  (clk),
    .we   (sq_we),
    .waddr(sq_waddr),
    .wdata(sq_wdata),
    .re   (sq_re),
    .raddr(s1_apid),
    .rdata(sq_q)
  );

  // capture a write made on the same edge as the read
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (s1_adv) begin
      fwd_valid <= sq_byte_we;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      fwd_addr <= sq_waddr;
      fwd_data <= sq_wdata;
    end
  end

  // segment size limit
  always_comb begin
    priority if (max_seg < SEG_MIN) begin
      lim = SEG_MIN;
    end else if (max_seg > SEG_MAX) begin
      lim = SEG_MAX;
    end else begin
      lim = max_seg;
    end
  end

  // segmentation for the byte in stage 2
  always_comb begin
    base_cnt  = (fwd_valid && (fwd_addr == s2_apid)) ? fwd_data : sq_q;
    apid_v    = s2_ctl.pkt_first ? s2_apid : cur_apid;
    bytes_v   = s2_ctl.pkt_first ? '0 : bytes_in_seg;
    first_v   = s2_ctl.pkt_first || first_flag;
    cnt_src   = s2_ctl.pkt_first ? base_cnt : cur_cnt;
    cnt_inc   = cnt_src + 1'b1;
    start_v   = (bytes_v == '0);
    seq_v     = start_v ? cnt_src : cur_seq;
    bytes_inc = bytes_v + 1'b1;
    end_v     = s2_ctl.last || (bytes_inc >= lim);
  end

  // segment state
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_in_seg <= '0;
      first_flag   <= 1'b0;
    end else if (s2_adv) begin
      bytes_in_seg <= end_v ? '0 : bytes_inc;
      first_flag   <= end_v ? 1'b0 : first_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      cur_apid <= apid_v;
      cur_seq  <= seq_v;
      cur_cnt  <= start_v ? cnt_inc : cnt_src;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s2_adv) begin
      o_valid <= 1'b1;
    end else if (o_ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      o_byte      <= s2_byte;
      o_apid      <= apid_v;
      o_seq       <= seq_v;
      o_first_seg <= first_v;
      o_last_seg  <= s2_ctl.last;
      o_seg_start <= start_v;
      o_seg_end   <= end_v;
    end
  end

  // the packet's last byte always closes its segment
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_last_seg |-> o_seg_end)
    else $error("last byte of packet without segment end");

  // byte count never passes the largest segment
  a_bytes_bound: assert property (@(posedge clk) disable iff (rst)
    bytes_in_seg < SEG_MAX)
    else $error("segment byte count out of range");

endmodule

[rtl/core/space_packet_segmenter_unit.sv]
// space packet segmenter
// input stream (s_*): one beat per packet byte or per remap entry write.
//   s_tuser selects the beat kind: 0 writes an apid remap entry, 1 carries
//   a packet byte. s_tlast marks the final byte of a source packet. the
//   source apid is sampled on the first byte of each packet.
// output stream (m_*): one beat per packet byte with its segment apid,
//   sequence count and segment flags; m_tlast marks the packet's last byte.
// cfg_*: writes the largest segment data size in bytes (clamped 16..65536);
//   always ready; the user must see that it is written only while no bytes
//   are in flight, since the block itself does not enforce this.
// throughput: one beat per cycle unless stalled; the remap table and the
//   per-apid sequence counters sit in registered single-port-read memories,
//   looked up once per packet, with same-edge write forwarding on counters.
// reset: a clearing pass over every apid address empties the remap table and
//   zeroes all sequence counters; s_tready stays low until it ends.
// a stalled receiver holds the output register; stages behind it keep
//   filling, and s_tready drops only once the pipeline is full.
module space_packet_segmenter_unit import sps_pkg::*; #(
  parameter int APID_BITS = 11,
  parameter int SEQ_BITS  = 14,
  localparam int IN_TW  = ((3 * APID_BITS + BYTE_W + 7) / 8) * 8,
  localparam int OUT_TW = ((BYTE_W + APID_BITS + SEQ_BITS + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  // input stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_TW-1:0]  s_tdata,  // map_orig_apid, map_seg_apid, data_byte, src_apid
  input  logic              s_tuser,  // action
  input  logic              s_tlast,  // src_last
  // output stream
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_TW-1:0] m_tdata,  // out_byte, out_apid, out_sequence
  output logic [2:0]        m_tuser,  // first_segment, segment_start, segment_end
  output logic              m_tlast,  // last_segment
  // configuration
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_data  // max_segment_bytes
);

  logic                 clr_active;
  logic [APID_BITS-1:0] clr_addr;
  logic [CFG_W-1:0]     max_seg;
  logic                 acc;
  logic                 take;
  logic                 s1_adv;
  item_ctl_t            s1_ctl;
  logic [BYTE_W-1:0]    s1_byte;
  logic [APID_BITS-1:0] s1_apid;

  logic [BYTE_W-1:0]    o_byte;
  logic [APID_BITS-1:0] o_apid;
  logic [SEQ_BITS-1:0]  o_seq;
  logic                 o_first_seg;
  logic                 o_seg_start;
  logic                 o_seg_end;

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == '1) begin
        clr_active <= 1'b0;
      end
    end
  end

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_seg <= SEG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_seg <= cfg_data;
    end
  end

  // input handshake
  assign s1_adv   = s1_ctl.valid && take;
  assign s_tready = !clr_active && (!s1_ctl.valid || take);
  assign acc      = s_tvalid && s_tready;

  sps_remap #(
    .APID_BITS(APID_BITS)
  ) u_remap (
    .clk          (clk),
    .rst          (rst),
    .clr_active   (clr_active),
    .clr_addr     (clr_addr),
    .acc          (acc),
    .action       (s_tuser),
    .map_orig_apid(s_tdata[APID_BITS-1:0]),
    .map_seg_apid (s_tdata[2*APID_BITS-1:APID_BITS]),
    .data_byte    (s_tdata[2*APID_BITS+BYTE_W-1:2*APID_BITS]),
    .src_apid     (s_tdata[3*APID_BITS+BYTE_W-1:2*APID_BITS+BYTE_W]),
    .src_last     (s_tlast),
    .s1_adv       (s1_adv),
    .s1_ctl       (s1_ctl),
    .s1_byte      (s1_byte),
    .s1_apid      (s1_apid)
  );

  sps_segment #(
    .APID_BITS(APID_BITS),
    .SEQ_BITS (SEQ_BITS)
  ) u_segment (
    .clk        (clk),
    .rst        (rst),
    .clr_active (clr_active),
    .clr_addr   (clr_addr),
    .max_seg    (max_seg),
    .s1_ctl     (s1_ctl),
    .s1_byte    (s1_byte),
    .s1_apid    (s1_apid),
    .take       (take),
    .o_valid    (m_tvalid),
    .o_ready    (m_tready),
    .o_byte     (o_byte),
    .o_apid     (o_apid),
    .o_seq      (o_seq),
    .o_first_seg(o_first_seg),
    .o_last_seg (m_tlast),
    .o_seg_start(o_seg_start),
    .o_seg_end  (o_seg_end)
  );

  // output beat packing
  assign m_tdata = OUT_TW'({o_seq, o_apid, o_byte});
  assign m_tuser = {o_seg_end, o_seg_start, o_first_seg};

  // no beat enters while the memories are being cleared
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    clr_active |-> !s_tready)
    else $error("input accepted during clearing pass");

endmodule
